// File: hdl/button_debounce_note_events_top_defines.svh
// Assertion macros used by the checker file of the button debouncer.
// Depends on nothing; include it inside a module body.
`ifndef BUTTON_DEBOUNCE_NOTE_EVENTS_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_NOTE_EVENTS_TOP_DEFINES_SVH

// Whenever the antecedent holds at a clock edge, the consequent must hold too.
`define BDE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds at an edge, the consequent must hold at the next edge.
`define BDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bde_pkg.sv
// Package of the button debouncer: payload structs, record store structs,
// field widths and the button-to-note mapping. Depends on nothing.
`default_nettype none

package bde_pkg;

	localparam int BUTTONS = 64;
	localparam int IDX_W = 6;
	localparam int TIME_W = 6;
	localparam int NOTE_W = 8;

	localparam logic [TIME_W-1:0] HOLD_RESET = 6'd1;
	localparam logic [3:0] ROW_LEN = 4'd6;
	localparam logic [NOTE_W-1:0] NOTE_ROW = 8'd13;
	// 43/256 is close enough to 1/6 that the quotient is exact for indexes below 64.
	localparam logic [11:0] DIV6_RECIP = 12'd43;

	typedef struct packed {
		logic [IDX_W-1:0] btn_id;
		logic live_level;
		logic [TIME_W-1:0] time_ms;
	} sample_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note_number;
		logic note_on;
	} note_t;

	// Record of one button as seen by the update logic.
	typedef struct packed {
		logic level;
		logic pend;
		logic wrap;
		logic [TIME_W-1:0] start;
	} st_rd_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		logic level;
		logic pend;
		logic wrap;
		logic [TIME_W-1:0] start;
	} st_wr_t;

	// Note number of a button: six buttons to a row, thirteen notes per row.
	function automatic logic [NOTE_W-1:0] note_of(input logic [IDX_W-1:0] idx);
		logic [11:0] prod;
		logic [3:0] q;
		logic [5:0] r;
		prod = {6'b0, idx} * DIV6_RECIP;
		q = prod[11:8];
		r = idx - 6'({2'b0, q} * {2'b0, ROW_LEN});
		return 8'({4'b0, q} * NOTE_ROW) + {2'b0, r};
	endfunction

endpackage

`default_nettype wire

// File: hdl/bde_store.sv
// Per-button record store: pending and written flags in flip-flops; debounced
// level, start time and wrap flag in a memory with a registered, forwarded
// read port. Depends on bde_pkg.
`default_nettype none

module bde_store (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [bde_pkg::IDX_W-1:0] rd_idx,
	input  bde_pkg::st_wr_t wr,
	output bde_pkg::st_rd_t rd
);
	import bde_pkg::*;

	logic [BUTTONS-1:0] seen_q;
	logic [BUTTONS-1:0] pend_q;
	logic [IDX_W-1:0] idx_q;
	logic [TIME_W+1:0] mem [BUTTONS];
	logic [TIME_W+1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			pend_q <= '0;
			idx_q <= '0;
		end else begin
			if (rd_en) begin
				idx_q <= rd_idx;
			end
			if (wr.en) begin
				seen_q[wr.idx] <= 1'b1;
				pend_q[wr.idx] <= wr.pend;
			end
		end
	end

	// A write to the address being read in the same cycle is forwarded, so a
	// sample that follows one of the same button sees the updated record.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= {wr.level, wr.wrap, wr.start};
		end
		if (rd_en) begin
			if (wr.en && wr.idx == rd_idx) begin
				rdata_q <= {wr.level, wr.wrap, wr.start};
			end else begin
				rdata_q <= mem[rd_idx];
			end
		end
	end

	// A button never written since reset reads as released.
	assign rd.level = seen_q[idx_q] & rdata_q[TIME_W+1];
	assign rd.pend = pend_q[idx_q];
	assign rd.wrap = rdata_q[TIME_W];
	assign rd.start = rdata_q[TIME_W-1:0];

endmodule

`default_nettype wire

// File: hdl/button_debounce_note_events_top.sv
// Top level of the button debouncer with note events.
// Depends on bde_pkg and bde_store.
`default_nettype none

// Takes one button sample per cycle, unless a note waits at a stalled output,
// and keeps a debounced level per button. A level change that persists for
// hold_ms milliseconds (on a 64 ms wrapping clock) flips the debounced level
// and emits one note transaction: note on for a press, note off for a release.
// The sustained rate is one sample per clock while the output is not stalled.
// The sample and its button's record are registered together when the sample
// is taken, and the note then loads into the result register once the output
// is free. Samples that cause no note never wait on the output.

module button_debounce_note_events_top (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  bde_pkg::sample_t sample,
	output logic note_valid,
	input  logic note_stall,
	output bde_pkg::note_t note,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bde_pkg::TIME_W-1:0] cfg_data
);
	import bde_pkg::*;

	logic [TIME_W-1:0] hold_q;
	logic valid_s1;
	sample_t item_s1;
	logic note_valid_q;
	note_t note_q;

	st_rd_t rd;
	st_wr_t wr;

	logic accept;
	logic in_range;
	logic same;
	logic held;
	logic emit;
	logic out_free;
	logic s1_done;
	logic [TIME_W:0] end_sum;
	logic [TIME_W:0] start_sum;
	logic [TIME_W-1:0] t;

	bde_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_idx(sample.btn_id),
		.wr(wr),
		.rd(rd)
	);

	assign t = item_s1.time_ms;
	assign in_range = ({1'b0, item_s1.btn_id} < 7'(BUTTONS));
	assign same = (item_s1.live_level == rd.level);
	assign end_sum = {1'b0, rd.start} + {1'b0, hold_q};
	assign start_sum = {1'b0, t} + {1'b0, hold_q};

	always_comb begin
		if (rd.wrap) begin
			held = (end_sum[TIME_W-1:0] <= t) && (rd.start > t);
		end else begin
			held = !((rd.start <= t) && (end_sum > {1'b0, t}));
		end
	end

	assign emit = valid_s1 && in_range && !same && rd.pend && held;
	assign out_free = !note_valid_q || !note_stall;
	assign s1_done = valid_s1 && (!emit || out_free);
	assign sample_stall = valid_s1 && !s1_done;
	assign accept = sample_valid && !sample_stall;

	// A record that is already pending keeps its start time until it resolves.
	always_comb begin
		wr.en = s1_done && in_range;
		wr.idx = item_s1.btn_id;
		wr.level = emit ? ~rd.level : rd.level;
		wr.pend = !same && (!rd.pend || !held);
		wr.wrap = rd.pend ? rd.wrap : start_sum[TIME_W];
		wr.start = rd.pend ? rd.start : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
			valid_s1 <= 1'b0;
			note_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				hold_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (emit && s1_done) begin
				note_valid_q <= 1'b1;
			end else if (!note_stall) begin
				note_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
		if (emit && s1_done) begin
			note_q.note_number <= note_of(item_s1.btn_id);
			note_q.note_on <= item_s1.live_level;
		end
	end

	assign note_valid = note_valid_q;
	assign note = note_q;
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// File: hdl/bde_checker.sv
// Port-level checker for the button debouncer and its bind to the top level.
// Depends on bde_pkg and button_debounce_note_events_top_defines.svh.
`default_nettype none

module bde_checker (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_stall,
	input bde_pkg::sample_t sample,
	input logic note_valid,
	input logic note_stall,
	input bde_pkg::note_t note,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [bde_pkg::TIME_W-1:0] cfg_data
);
	import bde_pkg::*;
	`include "button_debounce_note_events_top_defines.svh"

	// A stalled note transaction must hold until it is taken.
	`BDE_ASSERT_NEXT(a_note_hold, clk, arst_n, note_valid && note_stall, note_valid && $stable(note), "note changed while stalled")

	// Samples are only held back by a note that waits at the output.
	`BDE_ASSERT_IMPL(a_stall_cause, clk, arst_n, sample_stall, note_valid && note_stall, "sample stalled without a waiting note")

	// A fresh note rises only after an accepted sample has passed through the sample register and the result register.
	`BDE_ASSERT_IMPL(a_note_latency, clk, arst_n, $rose(note_valid), $past(sample_valid && !sample_stall, 2), "note without a sample two cycles earlier")

	// Six buttons to a row of thirteen notes keeps every note number below 134.
	`BDE_ASSERT_IMPL(a_note_range, clk, arst_n, note_valid, note.note_number <= 8'd133, "note number out of range")

endmodule

bind button_debounce_note_events_top bde_checker u_bde_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_stall(sample_stall),
	.sample(sample),
	.note_valid(note_valid),
	.note_stall(note_stall),
	.note(note),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_data(cfg_data)
);

`default_nettype wire
